### rtl/core/rte_pkg.sv
// shared types, constants and column helpers for the rpn truth table evaluator
package rte_pkg;

	// sizes
	localparam int MAX_VARS    = 6;
	localparam int STACK_DEPTH = 16;
	localparam int COL_W       = 64;
	localparam int VC_W        = 3;
	localparam int IDX_W       = 3;
	localparam int OP_W        = 3;
	localparam int ERR_W       = 2;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// register port
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam logic REG_VAR_COUNT = 1'b0;
	localparam logic [VC_W-1:0] VAR_COUNT_RESET = 3'd1;

	// token kinds
	localparam logic MODE_VAR = 1'b0;
	localparam logic MODE_OP  = 1'b1;

	// operator codes
	localparam logic [OP_W-1:0] OP_NOT  = 3'd0;
	localparam logic [OP_W-1:0] OP_AND  = 3'd1;
	localparam logic [OP_W-1:0] OP_OR   = 3'd2;
	localparam logic [OP_W-1:0] OP_IMP  = 3'd3;
	localparam logic [OP_W-1:0] OP_XOR  = 3'd4;
	localparam logic [OP_W-1:0] OP_EQU  = 3'd5;
	localparam logic [OP_W-1:0] OP_NAND = 3'd6;
	localparam logic [OP_W-1:0] OP_NOR  = 3'd7;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_VAR   = 2'd3;

	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  var_index;
		logic [OP_W-1:0]   op_code;
		logic              last_token;
	} token_t;

	typedef struct packed {
		logic [COL_W-1:0]  truth_column;
		logic [ERR_W-1:0]  error_code;
	} result_t;

	// stack moves requested by the evaluation logic
	typedef struct packed {
		logic push;
		logic pop;
		logic wr_top;
	} stk_ctrl_t;

	// variable count in use, clamped to 1..MAX_VARS
	function automatic logic [VC_W-1:0] eff_vars(input logic [VC_W-1:0] vc);
		logic [VC_W-1:0] v;
		if (vc == '0) begin
			v = VC_W'(1);
		end else if (vc > VC_W'(MAX_VARS)) begin
			v = VC_W'(MAX_VARS);
		end else begin
			v = vc;
		end
		return v;
	endfunction

	// ones on every row below 2^v
	function automatic logic [COL_W-1:0] row_mask(input logic [VC_W-1:0] v);
		logic [COL_W-1:0] m;
		logic [7:0]       rows;
		rows = 8'd1 << v;
		for (int j = 0; j < COL_W; j++) begin
			m[j] = (8'(j) < rows);
		end
		return m;
	endfunction

	// column of variable idx: row j takes bit (v-1-idx) of j
	function automatic logic [COL_W-1:0] var_column(input logic [IDX_W-1:0] idx,
			input logic [VC_W-1:0] v);
		logic [COL_W-1:0] c;
		logic [2:0]       sh;
		logic [7:0]       jj;
		sh = 3'(v - VC_W'(1) - idx);
		for (int j = 0; j < COL_W; j++) begin
			jj   = 8'(j);
			c[j] = jj[sh];
		end
		return c;
	endfunction

endpackage

### rtl/core/rpn_truth_table_evaluator_unit.sv
// top level of the rpn truth table evaluator
// Postfix Boolean expressions arrive one token per transaction and are evaluated over the
// whole truth table at once: each stack entry is a 64-bit column, bit j holding row j, with
// 2^var_count rows in use, var_count clamped to 1..6. A token enters an input register and
// is applied to the register stack; one token is accepted every cycle unless stalled, and the
// result of the token marked last goes into the output register. Only the output register can
// hold the line back: when a result is waiting and stalled, a last token waits in the input
// register. The first error of an expression is kept and reported with the final column;
// stack and error clear after each result. var_count is at byte address 0 of the register
// port; write it only while no transaction is in flight; the block does not enforce it.
module rpn_truth_table_evaluator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rte_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rte_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rte_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rte_pkg::token_t                 in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output rte_pkg::result_t                out_data
);
	import rte_pkg::*;

	logic             valid_s1;
	token_t           token_s1;
	logic [VC_W-1:0]  var_count;
	logic [COL_W-1:0] top;
	logic [COL_W-1:0] sec;
	logic [CNT_W-1:0] count;
	stk_ctrl_t        ctrl;
	logic [COL_W-1:0] top_d;
	logic [ERR_W-1:0] alu_err;
	logic [COL_W-1:0] column;
	logic             empty;
	logic [ERR_W-1:0] sticky_q;
	logic [ERR_W-1:0] sticky_next;
	logic             advance;
	logic             fire;
	logic             fire_last;
	logic             out_valid_q;
	result_t          out_data_q;

	rte_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.var_count (var_count)
	);

	// the token in the input register moves on unless its result has nowhere to go
	assign advance   = !token_s1.last_token || !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign fire_last = fire && token_s1.last_token;
	assign in_stall  = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			token_s1 <= in_data;
		end
	end

	rte_token_alu u_alu (
		.token     (token_s1),
		.var_count (var_count),
		.top       (top),
		.sec       (sec),
		.count     (count),
		.ctrl      (ctrl),
		.top_d     (top_d),
		.err       (alu_err),
		.column    (column),
		.empty     (empty)
	);

	rte_col_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.clear  (token_s1.last_token),
		.ctrl   (ctrl),
		.top_d  (top_d),
		.top    (top),
		.sec    (sec),
		.count  (count)
	);

	// first error of the expression wins
	assign sticky_next = (sticky_q != ERR_NONE) ? sticky_q : alu_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= ERR_NONE;
		end else if (fire) begin
			sticky_q <= token_s1.last_token ? ERR_NONE : sticky_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_last) begin
			out_data_q.truth_column <= column;
			out_data_q.error_code   <= (empty && sticky_next == ERR_NONE) ?
				ERR_UNDER : sticky_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/core/rte_cfg_regs.sv
// register port holding the variable count
module rte_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rte_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rte_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rte_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [rte_pkg::VC_W-1:0]        var_count
);
	import rte_pkg::*;

	logic [VC_W-1:0] var_count_q;
	logic            wr_en;
	logic            sel_vc;

	assign pready = 1'b1;
	assign sel_vc = (paddr[2] == REG_VAR_COUNT);
	assign wr_en  = psel && penable && pwrite && pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= VAR_COUNT_RESET;
		end else if (wr_en && sel_vc) begin
			var_count_q <= pwdata[VC_W-1:0];
		end
	end

	// read back
	assign prdata    = sel_vc ? APB_DATA_W'(var_count_q) : '0;
	assign var_count = var_count_q;

endmodule

### rtl/core/rte_token_alu.sv
// combinational evaluation of one token against the two top stack columns
module rte_token_alu (
	input  rte_pkg::token_t               token,
	input  logic [rte_pkg::VC_W-1:0]      var_count,
	input  logic [rte_pkg::COL_W-1:0]     top,
	input  logic [rte_pkg::COL_W-1:0]     sec,
	input  logic [rte_pkg::CNT_W-1:0]     count,
	output rte_pkg::stk_ctrl_t            ctrl,
	output logic [rte_pkg::COL_W-1:0]     top_d,
	output logic [rte_pkg::ERR_W-1:0]     err,
	output logic [rte_pkg::COL_W-1:0]     column,
	output logic                          empty
);
	import rte_pkg::*;

	logic [VC_W-1:0]  v;
	logic [COL_W-1:0] mask;
	logic [COL_W-1:0] var_col;
	logic [COL_W-1:0] bin_res;
	logic [CNT_W-1:0] count_next;
	logic [COL_W-1:0] top_next;

	assign v       = eff_vars(var_count);
	assign mask    = row_mask(v);
	assign var_col = var_column(token.var_index, v);

	// two-operand operators, sec is the second popped
	always_comb begin
		unique case (token.op_code)
			OP_AND:  bin_res = sec & top;
			OP_OR:   bin_res = sec | top;
			OP_IMP:  bin_res = ~sec | top;
			OP_XOR:  bin_res = sec ^ top;
			OP_EQU:  bin_res = ~(sec ^ top);
			OP_NAND: bin_res = ~(sec & top);
			OP_NOR:  bin_res = ~(sec | top);
			default: bin_res = ~top;
		endcase
	end

	// stack move and error for this token
	always_comb begin
		ctrl  = '0;
		err   = ERR_NONE;
		top_d = top;
		if (token.mode == MODE_VAR) begin
			if (token.var_index >= v) begin
				err = ERR_VAR;
			end else if (count >= CNT_W'(STACK_DEPTH)) begin
				err = ERR_OVER;
			end else begin
				ctrl.push = 1'b1;
				top_d     = var_col & mask;
			end
		end else if (token.op_code == OP_NOT) begin
			if (count < CNT_W'(1)) begin
				err = ERR_UNDER;
			end else begin
				ctrl.wr_top = 1'b1;
				top_d       = ~top & mask;
			end
		end else begin
			if (count < CNT_W'(2)) begin
				err = ERR_UNDER;
			end else begin
				ctrl.pop = 1'b1;
				top_d    = bin_res & mask;
			end
		end
	end

	// result column as seen after this token
	always_comb begin
		count_next = count;
		if (ctrl.push) begin
			count_next = count + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_next = count - CNT_W'(1);
		end
	end

	assign top_next = (ctrl.push || ctrl.pop || ctrl.wr_top) ? top_d : top;
	assign empty    = (count_next == '0);
	assign column   = empty ? '0 : (top_next & mask);

endmodule

### rtl/core/rte_col_stack.sv
// shift-register column stack, top at entry zero
module rte_col_stack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          clear,
	input  rte_pkg::stk_ctrl_t            ctrl,
	input  logic [rte_pkg::COL_W-1:0]     top_d,
	output logic [rte_pkg::COL_W-1:0]     top,
	output logic [rte_pkg::COL_W-1:0]     sec,
	output logic [rte_pkg::CNT_W-1:0]     count
);
	import rte_pkg::*;

	logic [COL_W-1:0] ent_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;

	// entries shift down on push and up on pop
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctrl.push) begin
				ent_q[0] <= top_d;
				for (int k = 1; k < STACK_DEPTH; k++) begin
					ent_q[k] <= ent_q[k-1];
				end
			end else if (ctrl.pop) begin
				ent_q[0] <= top_d;
				for (int k = 1; k < STACK_DEPTH - 1; k++) begin
					ent_q[k] <= ent_q[k+1];
				end
			end else if (ctrl.wr_top) begin
				ent_q[0] <= top_d;
			end
		end
	end

	// fill count, emptied at the end of an expression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			if (clear) begin
				count_q <= '0;
			end else if (ctrl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign top   = ent_q[0];
	assign sec   = ent_q[1];
	assign count = count_q;

endmodule

### verif/tb_rpn_truth_table_evaluator_unit.sv
// self-checking testbench for the rpn truth table evaluator unit
module tb_rpn_truth_table_evaluator_unit;
	import rte_pkg::*;

	localparam int HOLD_CYCLES     = 120;
	localparam int SETTLE_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASE_COUNT     = 8;
	localparam int TOKENS_PER_PHASE = 106;
	localparam logic [APB_ADDR_W-1:0] VAR_COUNT_ADDR = APB_ADDR_W'(4 * REG_VAR_COUNT);

	// predicts the column and error of each expression and checks results in order
	class column_scoreboard;
		logic [COL_W-1:0] columns [STACK_DEPTH];
		int unsigned      depth_used = 0;
		logic [ERR_W-1:0] first_error = ERR_NONE;
		logic [VC_W-1:0]  var_count = VAR_COUNT_RESET;
		result_t          expected_results [$];
		int unsigned      mismatches = 0;

		function void set_var_count(input logic [VC_W-1:0] value);
			var_count = value;
		endfunction

		// variable count in use, out-of-range settings clamp to 1..MAX_VARS
		function logic [VC_W-1:0] active_vars();
			if (var_count == '0)
				return VC_W'(1);
			if (var_count > VC_W'(MAX_VARS))
				return VC_W'(MAX_VARS);
			return var_count;
		endfunction

		// only the first error of an expression is kept
		function void note_error(input logic [ERR_W-1:0] code);
			if (first_error == ERR_NONE)
				first_error = code;
		endfunction

		function void note_token(input token_t t);
			logic [VC_W-1:0]  v;
			logic [COL_W-1:0] rows;
			logic [COL_W-1:0] vcol;
			logic [COL_W-1:0] top;
			logic [COL_W-1:0] sec;
			logic [COL_W-1:0] r;
			result_t          res;
			int               sh;
			v = active_vars();
			rows = (v >= VC_W'(MAX_VARS)) ? '1 : ((COL_W'(1) << (1 << v)) - COL_W'(1));
			if (t.mode == MODE_VAR) begin
				if (t.var_index >= v) begin
					note_error(ERR_VAR);
				end else if (depth_used >= STACK_DEPTH) begin
					note_error(ERR_OVER);
				end else begin
					// row j of variable i is bit (v-1-i) of j
					vcol = '0;
					sh = int'(v) - 1 - int'(t.var_index);
					for (int j = 0; j < COL_W; j++) begin
						vcol[j] = ((j >> sh) & 1) != 0;
					end
					columns[depth_used] = vcol & rows;
					depth_used++;
				end
			end else if (t.op_code == OP_NOT) begin
				if (depth_used < 1)
					note_error(ERR_UNDER);
				else
					columns[depth_used-1] = ~columns[depth_used-1] & rows;
			end else if (depth_used < 2) begin
				note_error(ERR_UNDER);
			end else begin
				top = columns[depth_used-1];
				sec = columns[depth_used-2];
				// nor unless another operator applies
				r = ~(sec | top);
				case (t.op_code)
					OP_AND:  r = sec & top;
					OP_OR:   r = sec | top;
					OP_IMP:  r = ~sec | top;
					OP_XOR:  r = sec ^ top;
					OP_EQU:  r = ~(sec ^ top);
					OP_NAND: r = ~(sec & top);
					default: ;
				endcase
				depth_used--;
				columns[depth_used-1] = r & rows;
			end
			// final token hands out the top column and clears the expression
			if (t.last_token) begin
				if (depth_used == 0) begin
					note_error(ERR_UNDER);
					res.truth_column = '0;
				end else begin
					res.truth_column = columns[depth_used-1] & rows;
				end
				res.error_code = first_error;
				expected_results.insert(expected_results.size(), res);
				depth_used = 0;
				first_error = ERR_NONE;
			end
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result: truth_column %h error_code %0d",
					got.truth_column, got.error_code);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (got.truth_column !== want.truth_column) begin
				$error("truth_column: expected %h, actual %h", want.truth_column,
					got.truth_column);
				mismatches++;
			end
			if (got.error_code !== want.error_code) begin
				$error("error_code: expected %0d, actual %0d", want.error_code,
					got.error_code);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	token_t                in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	result_t               out_data;

	column_scoreboard sb = new;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               hold_asks = 0;
	int               tokens_sent = 0;
	int               quiet_cycles = 0;

	rpn_truth_table_evaluator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** rpn_truth_table_evaluator_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic token_t random_token();
		token_t t;
		t.mode       = 1'($urandom_range(1));
		t.var_index  = IDX_W'($urandom_range(7));
		t.op_code    = OP_W'($urandom_range(7));
		t.last_token = 1'($urandom_range(1));
		return t;
	endfunction

	// offer one token, called at a falling edge, returns at the falling edge after acceptance
	task automatic send_token(input token_t t);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_stall);
		sb.note_token(t);
		tokens_sent++;
		@(negedge clk);
	endtask

	task automatic push_var(input int idx, input bit last);
		token_t t;
		t = random_token();
		t.mode = MODE_VAR;
		t.var_index = IDX_W'(idx);
		t.last_token = last;
		send_token(t);
	endtask

	task automatic apply_op(input logic [OP_W-1:0] op, input bit last);
		token_t t;
		t = random_token();
		t.mode = MODE_OP;
		t.op_code = op;
		t.last_token = last;
		send_token(t);
	endtask

	// stop offering and wait until the block has nothing left in flight
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write: setup cycle then access cycle
	task automatic write_var_count(input logic [VC_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= VAR_COUNT_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_var_count(value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// postfix expression over random variables, optionally corrupted or cut short
	task automatic send_expression(input int leaves, input bit broken);
		token_t          t;
		int              depth;
		int              left;
		bit              done;
		logic [VC_W-1:0] v;
		v = sb.active_vars();
		depth = 0;
		left = leaves;
		while (left > 0 || depth > 1) begin
			t = random_token();
			if (depth >= 2 && (left == 0 || $urandom_range(2) == 0)) begin
				t.mode = MODE_OP;
				t.op_code = OP_W'($urandom_range(7, 1));
				depth--;
			end else if (depth >= 1 && $urandom_range(4) == 0) begin
				t.mode = MODE_OP;
				t.op_code = OP_NOT;
			end else begin
				t.mode = MODE_VAR;
				t.var_index = IDX_W'($urandom_range(v - 1));
				left--;
				depth++;
			end
			done = (left == 0 && depth == 1);
			if (broken && $urandom_range(9) == 0)
				t = random_token();
			t.last_token = done || (broken && $urandom_range(15) == 0);
			send_token(t);
			if (t.last_token)
				break;
		end
	endtask

	initial begin : stimulus
		logic [VC_W-1:0] phase_vars [PHASE_COUNT] = '{3'd6, 3'd1, 3'd3, 3'd7,
			3'd0, 3'd2, 3'd4, 3'd5};
		int              send_pcts [4] = '{0, 73, 0, 17};
		int              stall_pcts [4] = '{0, 0, 73, 17};
		int              target;
		int              pick;
		token_t          t;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset value of var_count: one variable
		push_var(0, 1'b1);
		drain_results();

		// overflow on a full stack, every operator, entries left below the top
		write_var_count(3'd6);
		for (int k = 0; k < STACK_DEPTH + 1; k++)
			push_var(k % MAX_VARS, 1'b0);
		apply_op(OP_AND, 1'b0);
		apply_op(OP_OR, 1'b0);
		apply_op(OP_IMP, 1'b0);
		apply_op(OP_XOR, 1'b0);
		apply_op(OP_EQU, 1'b0);
		apply_op(OP_NAND, 1'b0);
		apply_op(OP_NOR, 1'b0);
		apply_op(OP_NOT, 1'b1);

		// variable out of range, sticky, column still reported
		push_var(6, 1'b0);
		push_var(7, 1'b0);
		push_var(0, 1'b1);

		// underflow on an empty stack, then empty at the end
		apply_op(OP_NOT, 1'b0);
		push_var(7, 1'b0);
		apply_op(OP_AND, 1'b1);
		drain_results();

		// var_count changes in the middle of an expression
		write_var_count(3'd3);
		push_var(0, 1'b0);
		push_var(2, 1'b0);
		drain_results();
		write_var_count(3'd5);
		push_var(4, 1'b0);
		apply_op(OP_OR, 1'b0);
		apply_op(OP_XOR, 1'b1);
		drain_results();

		// register settings outside 1..MAX_VARS
		write_var_count(3'd0);
		push_var(0, 1'b0);
		push_var(1, 1'b1);
		drain_results();
		write_var_count(3'd7);
		push_var(5, 1'b0);
		apply_op(OP_NOT, 1'b1);
		drain_results();

		// random phases over var_count settings and idle patterns
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_var_count(phase_vars[p]);
			send_idle_pct = send_pcts[p % 4];
			stall_pct = stall_pcts[p % 4];
			if (p % 4 == 0)
				hold_asks++;
			target = tokens_sent + TOKENS_PER_PHASE;
			while (tokens_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					send_expression(($urandom_range(19) == 0) ? $urandom_range(20, 12) :
						$urandom_range(6, 1), 1'b0);
				end else if (pick < 88) begin
					send_expression($urandom_range(8, 1), 1'b1);
				end else begin
					t = random_token();
					send_token(t);
				end
			end
			drain_results();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** rpn_truth_table_evaluator_unit: PASSED **");
		else
			$display("** rpn_truth_table_evaluator_unit: FAILED **");
		$finish;
	end

endmodule
